### rtl/kvi_pkg.sv
// Package: shared types and constants for the keyframe vec3 interpolator.
`timescale 1ns / 1ps
package kvi_pkg;

    // Field widths
    localparam int FRAME_W = 16;
    localparam int VAL_W   = 32;
    localparam int QUERY_W = 24;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 6;
    localparam int LANES   = 3;

    // Stored key: {z, y, x, frame}
    localparam int KEY_W   = FRAME_W + LANES * VAL_W;

    // Stream payload widths
    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 96;

    // Divider: quotient bits (|b - a| < 2^32, plus rounding carry)
    localparam int DIV_STEPS = 33;
    localparam int DCNT_W    = 6;
    localparam int PROD_W    = VAL_W + QUERY_W + 1;

    // Opcodes carried on tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic REG_KEY_COUNT  = 1'b0;
    localparam logic REG_EMPTY_KIND = 1'b1;

    // 1.0 in Q16.16
    localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_MUL,
        ST_DIV,
        ST_BLEND,
        ST_FIN,
        ST_OUT
    } kvi_state_t;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_EMPTY,
        RES_PREV,
        RES_BLEND
    } kvi_res_t;

    typedef struct packed {
        logic     latch_query;
        logic     take_key;
        logic     start_blend;
        logic     mul;
        logic     div_step;
        kvi_res_t res_sel;
        logic     load_out;
    } kvi_cmd_t;

    typedef struct packed {
        logic hit;
        logic flat;
        logic out_busy;
    } kvi_status_t;

endpackage

### rtl/keyframe_vec3_interpolator.sv
// Top level: keyframe track store with linear vec3 interpolation.
// A load item is taken while idle and gives no result; one query is in work at a time.
// A query scans the keys one by one, each read from the registered key store and then checked;
// a blend then runs the multiply, a 33-step divide, the add and the output load. An output
// stall holds the result; the next item is taken in the cycle after the output load.
// Reset (rst_n, async low) clears control and config; the key store is not cleared.
`timescale 1ns / 1ps
module keyframe_vec3_interpolator
    import kvi_pkg::*;
#(
    parameter int MAX_KEYS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [COUNT_W-1:0]   cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // key_index, key_frame, value_x, value_y, value_z, query_frame, zero pad
    input  logic [S_DATA_W-1:0]  s_tdata,
    // opcode
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // out_x, out_y, out_z
    output logic [M_DATA_W-1:0]  m_tdata
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic [INDEX_W-1:0] key_index;
    logic [QUERY_W-1:0] query_frame;
    logic [KEY_W-1:0]   key_wr, key_rd;
    logic [AW-1:0]      raddr;
    logic [CW-1:0]      key_num;
    logic               key_we;
    kvi_cmd_t           cmd;
    kvi_status_t        status;

    // Unpack the input item
    assign key_index   = s_tdata[INDEX_W-1:0];
    assign key_wr      = s_tdata[INDEX_W +: KEY_W];
    assign query_frame = s_tdata[INDEX_W + KEY_W +: QUERY_W];

    // Key load: slots beyond the store are dropped
    assign key_we = s_tvalid && s_tready && (s_tuser[0] == OP_LOAD)
                 && (32'(key_index) < MAX_KEYS);

    kvi_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (AW'(key_index)),
        .wdata (key_wr),
        .raddr (raddr),
        .rdata (key_rd)
    );

    kvi_ctrl #(
        .MAX_KEYS (MAX_KEYS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser[0]),
        .key_num  (key_num),
        .status   (status),
        .cmd      (cmd),
        .raddr    (raddr)
    );

    kvi_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .query_frame (query_frame),
        .key_rd      (key_rd),
        .cmd         (cmd),
        .status      (status),
        .key_num     (key_num),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

### rtl/kvi_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kvi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/kvi_ctrl.sv
// Controller: key scan sequencer, divider step count and output hand-off.
`timescale 1ns / 1ps
module kvi_ctrl
    import kvi_pkg::*;
#(
    parameter int MAX_KEYS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic                           opcode,
    input  logic [$clog2(MAX_KEYS+1)-1:0]  key_num,
    input  kvi_status_t                    status,
    output kvi_cmd_t                       cmd,
    output logic [$clog2(MAX_KEYS)-1:0]    raddr
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    kvi_state_t        state_reg, state_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [CW-1:0]     idx_inc;

    assign idx_inc  = idx_reg + CW'(1);
    assign raddr    = idx_reg[AW-1:0];
    assign s_tready = (state_reg == ST_IDLE);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            dcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        dcnt_next  = dcnt_reg;
        cmd        = '{latch_query: 1'b0, take_key: 1'b0, start_blend: 1'b0, mul: 1'b0,
                       div_step: 1'b0, res_sel: RES_NONE, load_out: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && opcode == OP_QUERY)
                begin
                    cmd.latch_query = 1'b1;
                    idx_next        = '0;
                    if (key_num == '0)
                    begin
                        cmd.res_sel = RES_EMPTY;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // key 0 is always taken; later keys stop the scan on a hit
                if (idx_reg != '0 && status.hit)
                begin
                    if (status.flat)
                    begin
                        cmd.res_sel = RES_PREV;
                        state_next  = ST_OUT;
                    end
                    else
                    begin
                        cmd.start_blend = 1'b1;
                        state_next      = ST_MUL;
                    end
                end
                else
                begin
                    cmd.take_key = 1'b1;
                    idx_next     = idx_inc;
                    state_next   = (idx_inc == key_num) ? ST_FIN : ST_RD;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                cmd.res_sel = RES_BLEND;
                state_next  = ST_OUT;
            end
            ST_FIN:
            begin
                cmd.res_sel = RES_PREV;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/kvi_dp.sv
// Datapath: config registers, neighbour keys, three blend lanes, output register.
`timescale 1ns / 1ps
module kvi_dp
    import kvi_pkg::*;
#(
    parameter int MAX_KEYS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [COUNT_W-1:0]            cfg_data,
    input  logic [QUERY_W-1:0]            query_frame,
    input  logic [KEY_W-1:0]              key_rd,
    input  kvi_cmd_t                      cmd,
    output kvi_status_t                   status,
    output logic [$clog2(MAX_KEYS+1)-1:0] key_num,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [M_DATA_W-1:0]           m_tdata
);

    localparam int CW = $clog2(MAX_KEYS + 1);

    logic [COUNT_W-1:0] key_count_reg;
    logic               empty_kind_reg;
    logic [QUERY_W-1:0] query_reg;
    logic [FRAME_W-1:0] prev_frame_reg;
    logic [VAL_W-1:0]   prev_reg [LANES];
    logic [QUERY_W-1:0] num_reg;
    logic [QUERY_W-1:0] den_reg;
    logic [VAL_W-1:0]   mag_reg  [LANES];
    logic               neg_reg  [LANES];
    logic [QUERY_W-1:0] rem_reg  [LANES];
    logic [DIV_STEPS-1:0] qd_reg [LANES];
    logic [VAL_W-1:0]   res_reg  [LANES];
    logic [M_DATA_W-1:0] out_reg;
    logic               m_tvalid_reg;

    logic [FRAME_W-1:0] cur_frame;
    logic [VAL_W-1:0]   cur_val  [LANES];
    logic [QUERY_W-1:0] lf_ext, rf_ext, q_lo;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg  <= '0;
            empty_kind_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_COUNT:  key_count_reg  <= cfg_data;
                REG_EMPTY_KIND: empty_kind_reg <= cfg_data[0];
                default:        key_count_reg  <= key_count_reg;
            endcase
        end
    end

    // Keys in use, clamped to the store depth
    assign key_num = (32'(key_count_reg) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(key_count_reg);

    // Key just read and segment compare
    assign cur_frame = key_rd[FRAME_W-1:0];
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            cur_val[l] = key_rd[FRAME_W + l*VAL_W +: VAL_W];
        end
    end

    assign lf_ext = {prev_frame_reg, 8'h00};
    assign rf_ext = {cur_frame, 8'h00};
    assign q_lo   = (query_reg > lf_ext) ? query_reg : lf_ext;

    assign status.hit      = (query_reg <= rf_ext);
    assign status.flat     = (cur_frame <= prev_frame_reg);
    assign status.out_busy = m_tvalid_reg && !m_tready;

    // Query and left-hand key
    always_ff @(posedge clk)
    begin
        if (cmd.latch_query)
        begin
            query_reg <= query_frame;
        end
        if (cmd.take_key)
        begin
            prev_frame_reg <= cur_frame;
            for (int l = 0; l < LANES; l++)
            begin
                prev_reg[l] <= cur_val[l];
            end
        end
    end

    // Blend lanes: magnitude setup, multiply, restoring divide, result
    always_ff @(posedge clk)
    begin
        logic signed [VAL_W:0] diff;
        logic [PROD_W-1:0]     dvd;
        logic [QUERY_W:0]      trial;
        logic                  ge;
        if (cmd.start_blend)
        begin
            num_reg <= q_lo - lf_ext;
            den_reg <= rf_ext - lf_ext;
        end
        for (int l = 0; l < LANES; l++)
        begin
            diff  = $signed({cur_val[l][VAL_W-1], cur_val[l]})
                  - $signed({prev_reg[l][VAL_W-1], prev_reg[l]});
            dvd   = PROD_W'(mag_reg[l]) * PROD_W'(num_reg) + PROD_W'(den_reg >> 1);
            trial = {rem_reg[l], qd_reg[l][DIV_STEPS-1]};
            ge    = (trial >= {1'b0, den_reg});
            if (cmd.start_blend)
            begin
                neg_reg[l] <= diff[VAL_W];
                mag_reg[l] <= diff[VAL_W] ? VAL_W'(-diff) : VAL_W'(diff);
            end
            if (cmd.mul)
            begin
                rem_reg[l] <= QUERY_W'(dvd[PROD_W-2:DIV_STEPS]);
                qd_reg[l]  <= dvd[DIV_STEPS-1:0];
            end
            else if (cmd.div_step)
            begin
                rem_reg[l] <= ge ? QUERY_W'(trial - {1'b0, den_reg}) : trial[QUERY_W-1:0];
                qd_reg[l]  <= {qd_reg[l][DIV_STEPS-2:0], ge};
            end
            case (cmd.res_sel)
                RES_EMPTY: res_reg[l] <= empty_kind_reg ? ONE_Q16 : '0;
                RES_PREV:  res_reg[l] <= prev_reg[l];
                RES_BLEND: res_reg[l] <= neg_reg[l] ? prev_reg[l] - qd_reg[l][VAL_W-1:0]
                                                    : prev_reg[l] + qd_reg[l][VAL_W-1:0];
                default:   res_reg[l] <= res_reg[l];
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= {res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

endmodule

### tb/tb_keyframe_vec3_interpolator.sv
// Testbench: keyframe vec3 interpolator, stream stimulus checked against a built-in track model.
`timescale 1ns / 1ps
module tb_keyframe_vec3_interpolator
    import kvi_pkg::*;
();

    typedef struct packed {
        logic                        op;
        logic [INDEX_W-1:0]          idx;
        logic [FRAME_W-1:0]          frame;
        logic signed [VAL_W-1:0]     vx;
        logic signed [VAL_W-1:0]     vy;
        logic signed [VAL_W-1:0]     vz;
        logic [QUERY_W-1:0]          qf;
    } track_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
    } vec3_t;

    // Pending items carry a pause marker: when set the driver waits for drain first
    typedef struct packed {
        logic        drain_first;
        logic        is_cfg;
        logic        cfg_reg;
        logic [5:0]  cfg_val;
        track_item_t it;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [COUNT_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    keyframe_vec3_interpolator u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Model state
    logic [FRAME_W-1:0] key_frames [32];
    logic [VAL_W-1:0]   key_x [32];
    logic [VAL_W-1:0]   key_y [32];
    logic [VAL_W-1:0]   key_z [32];
    logic [5:0]         track_len = 0;
    logic               empty_ones = 0;

    pending_t    pending_q[$];
    vec3_t       expected_vecs[$];
    int          errors = 0;
    int          queries_checked = 0;
    int          loads_sent = 0;
    bit          stim_done = 0;
    int          hold_off = 0;

    initial forever #2 clk = ~clk;

    // Rounded blend of one component, halves away from zero
    function automatic logic [31:0] lerp_round(logic [31:0] a, logic [31:0] b,
                                               longint num, longint den);
        longint av, diff, mag, q;
        av = longint'($signed(a));
        diff = longint'($signed(b)) - av;
        mag = diff < 0 ? -diff : diff;
        q = (mag * num + den / 2) / den;
        return diff < 0 ? 32'(av - q) : 32'(av + q);
    endfunction

    function automatic vec3_t sample_track(logic [QUERY_W-1:0] qf);
        vec3_t r;
        int n;
        longint lf, rf, num, den;
        n = track_len > 32 ? 32 : track_len;
        if (n == 0)
        begin
            r.x = empty_ones ? ONE_Q16 : '0;
            r.y = r.x;
            r.z = r.x;
            return r;
        end
        r = {key_x[0], key_y[0], key_z[0]};
        for (int i = 1; i < n; i++)
        begin
            lf = longint'(key_frames[i-1]) << 8;
            rf = longint'(key_frames[i]) << 8;
            if (longint'(qf) <= rf)
            begin
                if (rf <= lf)
                    r = {key_x[i-1], key_y[i-1], key_z[i-1]};
                else
                begin
                    num = (longint'(qf) > lf ? longint'(qf) : lf) - lf;
                    den = rf - lf;
                    r.x = lerp_round(key_x[i-1], key_x[i], num, den);
                    r.y = lerp_round(key_y[i-1], key_y[i], num, den);
                    r.z = lerp_round(key_z[i-1], key_z[i], num, den);
                end
                return r;
            end
            r = {key_x[i], key_y[i], key_z[i]};
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cfg(logic r, logic [5:0] v, bit drain);
        pending_t p;
        p = '0;
        p.drain_first = drain;
        p.is_cfg = 1'b1;
        p.cfg_reg = r;
        p.cfg_val = v;
        pending_q.push_back(p);
    endtask

    task automatic add_load(int idx, logic [15:0] fr, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
        pending_t p;
        p = '0;
        p.it = {OP_LOAD, 5'(idx), fr, x, y, z, 24'($urandom)};
        pending_q.push_back(p);
    endtask

    task automatic add_query(logic [23:0] qf, bit drain);
        pending_t p;
        p = '0;
        p.drain_first = drain;
        p.it = {OP_QUERY, 5'($urandom), 16'($urandom), rand_val(), rand_val(), rand_val(), qf};
        pending_q.push_back(p);
    endtask

    // Fills a track of n keys with ascending frames, occasionally equal or descending
    task automatic build_track(int n, int span);
        int fr;
        fr = $urandom_range(0, 200);
        for (int i = 0; i < n; i++)
        begin
            add_load(i, 16'(fr), rand_val(), rand_val(), rand_val());
            case ($urandom_range(0, 9))
                0: fr = fr;
                1: fr = fr > 3 ? fr - 3 : fr;
                default: fr = fr + $urandom_range(1, span);
            endcase
            if (fr > 65535) fr = 65535;
        end
    endtask

    // Stimulus
    initial
    begin
        int n, nq, items, phase;
        // directed: empty track both kinds
        add_query(24'h0, 0);
        add_query(24'hFFFFFF, 0);
        add_cfg(REG_EMPTY_KIND, 6'd1, 1);
        add_query(24'h123456, 0);
        add_cfg(REG_EMPTY_KIND, 6'd0, 1);
        // extreme keys, equal and descending frames, out of range count
        add_load(0, 16'd10, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        add_load(1, 16'd20, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        add_load(2, 16'd20, 32'h1234_5678, 32'h0, 32'h1);
        add_load(3, 16'd5, 32'h0, 32'h0, 32'h0);
        add_load(4, 16'hFFFF, 32'hFFFF_0000, 32'h0001_0000, 32'h5555_5555);
        add_cfg(REG_KEY_COUNT, 6'd1, 1);
        add_query(24'd0, 0);
        add_cfg(REG_KEY_COUNT, 6'd5, 1);
        add_query(24'd0, 0);
        add_query(24'd2560, 0);
        add_query(24'd3840, 0);
        add_query(24'd3841, 0);
        add_query(24'd5119, 0);
        add_query(24'd5120, 0);
        add_query(24'hFFFFFF, 0);
        for (int i = 5; i < 32; i++)
            add_load(i, 16'hFFFF, rand_val(), rand_val(), rand_val());
        add_cfg(REG_KEY_COUNT, 6'd63, 1);
        add_query(24'hFFFF00, 0);
        add_query(24'hFFFFFF, 0);
        items = 30;
        phase = 0;
        // random phases: a fresh track then queries around it
        while (items < 1250)
        begin
            n = (phase % 8 == 7) ? 32 : $urandom_range(0, 8);
            build_track(n, (phase % 3 == 0) ? 2000 : 20);
            add_cfg(REG_KEY_COUNT, 6'((phase % 11 == 5) ? $urandom_range(33, 63) : n), 1);
            add_cfg(REG_EMPTY_KIND, 6'($urandom_range(0, 1)), 0);
            nq = $urandom_range(10, 30);
            for (int k = 0; k < nq; k++)
                add_query($urandom_range(0, 9) == 0 ? 24'($urandom) :
                          24'($urandom_range(0, 40000)), k == nq / 2 && phase % 5 == 0);
            items += n + nq;
            phase++;
        end
        stim_done = 1;
    end

    // Cycles since last accept of any kind, for the settle before config writes
    int idle_cycles = 0;
    function automatic bit quiet();
        return idle_cycles > 110;
    endfunction

    // Driver
    int gap = 0;
    bit offering = 0;
    bit cfg_fire = 0;
    pending_t cur;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            cfg_we <= 1'b0;
            offering = 0;
            gap = 0;
        end
        else
        begin
            cfg_fire = 1'b0;
            if (offering && s_tvalid && s_tready)
            begin
                if (cur.it.op == OP_QUERY)
                    expected_vecs.push_back(sample_track(cur.it.qf));
                else
                begin
                    loads_sent++;
                    key_frames[cur.it.idx] = cur.it.frame;
                    key_x[cur.it.idx] = cur.it.vx;
                    key_y[cur.it.idx] = cur.it.vy;
                    key_z[cur.it.idx] = cur.it.vz;
                end
                offering = 0;
                gap = $urandom_range(0, 6);
            end
            if (!offering)
            begin
                if (gap > 0)
                begin
                    gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    cur = pending_q[0];
                    if (cur.drain_first && (expected_vecs.size() > 0 || !quiet()))
                        s_tvalid <= 1'b0;
                    else if (cur.is_cfg)
                    begin
                        void'(pending_q.pop_front());
                        cfg_fire = 1'b1;
                        cfg_index <= cur.cfg_reg;
                        cfg_data <= cur.cfg_val;
                        if (cur.cfg_reg == REG_KEY_COUNT)
                            track_len = cur.cfg_val;
                        else
                            empty_ones = cur.cfg_val[0];
                        s_tvalid <= 1'b0;
                    end
                    else
                    begin
                        void'(pending_q.pop_front());
                        offering = 1;
                        s_tvalid <= 1'b1;
                        s_tuser <= cur.it.op;
                        s_tdata <= {3'b000, cur.it.qf, cur.it.vz, cur.it.vy, cur.it.vx,
                                    cur.it.frame, cur.it.idx};
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
            cfg_we <= cfg_fire;
        end
    end

    // Monitor and receiver idling
    int rgap = 0;
    vec3_t got, exp_v;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rgap = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]};
                if (expected_vecs.size() == 0)
                begin
                    $error("result with nothing expected: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp_v = expected_vecs.pop_front();
                    queries_checked++;
                    if (got.x !== exp_v.x)
                    begin
                        $error("out_x expected %h actual %h", exp_v.x, got.x);
                        errors++;
                    end
                    if (got.y !== exp_v.y)
                    begin
                        $error("out_y expected %h actual %h", exp_v.y, got.y);
                        errors++;
                    end
                    if (got.z !== exp_v.z)
                    begin
                        $error("out_z expected %h actual %h", exp_v.z, got.z);
                        errors++;
                    end
                end
                rgap = $urandom_range(0, 6);
                if (queries_checked == 40)
                    hold_off = 400;
            end
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else if (rgap > 0)
            begin
                rgap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= (queries_checked > 300 && queries_checked < 360) ? 1'b1 :
                            1'b1;
        end
    end

    // Watchdog and end of run
    int stall = 0;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            stall <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            stall <= stall + 1;
            idle_cycles <= idle_cycles + 1;
        end
        if (stall > 2000)
        begin
            $display("Some tests failed");
            $finish;
        end
        else if (stim_done && pending_q.size() == 0 && !offering &&
                 expected_vecs.size() == 0 && idle_cycles > 120)
        begin
            $display("Covered %0d loads and %0d checked queries over varied tracks,",
                     loads_sent, queries_checked);
            $display("empty, single key, equal and descending frames, clamped counts.");
            if (errors == 0)
                $display("All tests passed");
            else
                $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end
endmodule
